// ===== src/lfu_pkg.sv =====
package lfu_pkg;
   localparam int KeyWidth = 32;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 32;
   localparam int CfgWidth = 5;
   localparam logic [CfgWidth-1:0] CapReset = 5'd16;
   localparam logic [CountWidth-1:0] CountMax = 32'hFFFF_FFFF;
   localparam logic [ValueWidth-1:0] MissValue = 32'hFFFF_FFFF;

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                  req_type;
      logic [KeyWidth-1:0]   lookup_key;
      logic [ValueWidth-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [ValueWidth-1:0] read_value;
      logic                  evicted;
      logic [KeyWidth-1:0]   evicted_key;
   } rsp_type;
endpackage

// ===== src/lfu_req_if.sv =====
interface lfu_req_if;
   logic valid;
   logic ready;
   lfu_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/lfu_rsp_if.sv =====
interface lfu_rsp_if;
   logic valid;
   logic ready;
   lfu_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/lfu_cache_replacement_unit.sv =====
// LFU key/value store of CAPACITY fully associative entries, ties broken by
// least recent use. Each item (get or put) gives one result item. Entries
// live in a one-read-port synchronous memory. Every item starts with a scan
// pass that reads one entry per cycle to find the key, a free slot and the
// victim, followed by a decide state. A get that misses then presents its
// result. Any other item first runs an update pass that writes back the
// entry and the recency ranks before its result. A new item is accepted
// only once the result has been taken by rsp ready.
// csr_wr_en/csr_wr_data set the active capacity (0 acts as 1, above CAPACITY
// acts as CAPACITY). No clearing pass: valid bits reset at once.
module lfu_cache_replacement_unit #(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   lfu_req_if.sink req_if,
   lfu_rsp_if.source rsp_if,
   input  logic csr_wr_en,
   input  logic [lfu_pkg::CfgWidth-1:0] csr_wr_data
);
   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int RankW = IdxW;

   typedef struct packed {
      logic [lfu_pkg::KeyWidth-1:0]   key;
      logic [lfu_pkg::ValueWidth-1:0] value;
      logic [lfu_pkg::CountWidth-1:0] count;
      logic [RankW-1:0]               rank;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE, ST_RESP
   } state_type;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;
   logic [CAPACITY-1:0] valid_ff;

   state_type state_ff;
   logic [lfu_pkg::CfgWidth-1:0] cap_ff;
   logic [CntW-1:0] occ_ff;
   lfu_pkg::req_type req_ff;
   lfu_pkg::rsp_type rsp_ff;
   logic [CntW-1:0] ctr_ff;      // address issue counter
   logic rd_vld_ff;
   logic [IdxW-1:0] rd_idx_ff;
   logic found_ff, free_ff, vic_ff;
   logic [IdxW-1:0] found_idx_ff, free_idx_ff, vic_idx_ff, slot_ff;
   entry_type found_ent_ff, vic_ent_ff;
   logic [RankW:0] limit_ff;     // extra bit: all ranks below
   logic new_ent_ff;

   logic [CntW-1:0] eff_cap;
   always_comb begin
      if (cap_ff == '0) eff_cap = CntW'(1);
      else if (32'(cap_ff) > CAPACITY) eff_cap = CntW'(CAPACITY);
      else eff_cap = CntW'(cap_ff);
   end

   logic [IdxW-1:0] addr;
   assign addr = ctr_ff[IdxW-1:0];
   logic wr_en;
   entry_type wr_data;
   logic [IdxW-1:0] wr_addr;

   // memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = (state_ff == ST_RESP);
   assign rsp_if.payload = rsp_ff;

   logic scan_rd, upd_rd;
   assign scan_rd = (state_ff == ST_SCAN) && (32'(ctr_ff) < CAPACITY);
   assign upd_rd = (state_ff == ST_UPDATE) && (32'(ctr_ff) < CAPACITY);

   // update pass: write back the entry just read with its new rank
   always_comb begin
      wr_en = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      if (state_ff == ST_UPDATE && rd_vld_ff) begin
         if (rd_idx_ff == slot_ff) begin
            wr_en = 1'b1;
            wr_data.rank = '0;
            if (new_ent_ff) begin
               wr_data.key = req_ff.lookup_key;
               wr_data.value = req_ff.write_value;
               wr_data.count = 32'd1;
            end else begin
               if (req_ff.req_type == lfu_pkg::REQ_PUT)
                  wr_data.value = req_ff.write_value;
               if (rd_data_ff.count != lfu_pkg::CountMax)
                  wr_data.count = rd_data_ff.count + 32'd1;
            end
         end else if (valid_ff[rd_idx_ff] &&
                      {1'b0, rd_data_ff.rank} < limit_ff) begin
            wr_en = 1'b1;
            wr_data.rank = rd_data_ff.rank + RankW'(1);
         end
      end
   end

   logic better;
   always_comb begin
      better = !vic_ff || rd_data_ff.count < vic_ent_ff.count ||
               (rd_data_ff.count == vic_ent_ff.count &&
                rd_data_ff.rank > vic_ent_ff.rank);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= lfu_pkg::CapReset;
         occ_ff <= '0;
         valid_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         rd_vld_ff <= scan_rd || upd_rd;
         rd_idx_ff <= addr;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  req_ff <= req_if.payload;
                  ctr_ff <= '0;
                  found_ff <= 1'b0;
                  free_ff <= 1'b0;
                  vic_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_rd) ctr_ff <= ctr_ff + CntW'(1);
               if (rd_vld_ff) begin
                  if (!valid_ff[rd_idx_ff]) begin
                     if (!free_ff) begin
                        free_ff <= 1'b1;
                        free_idx_ff <= rd_idx_ff;
                     end
                  end else begin
                     if (!found_ff && rd_data_ff.key == req_ff.lookup_key) begin
                        found_ff <= 1'b1;
                        found_idx_ff <= rd_idx_ff;
                        found_ent_ff <= rd_data_ff;
                     end
                     if (better) begin
                        vic_ff <= 1'b1;
                        vic_idx_ff <= rd_idx_ff;
                        vic_ent_ff <= rd_data_ff;
                     end
                  end
               end
               if (!scan_rd && !rd_vld_ff) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               rsp_ff.hit <= found_ff;
               rsp_ff.read_value <= lfu_pkg::MissValue;
               rsp_ff.evicted <= 1'b0;
               rsp_ff.evicted_key <= '0;
               new_ent_ff <= 1'b0;
               ctr_ff <= '0;
               state_ff <= ST_UPDATE;
               if (found_ff) begin
                  slot_ff <= found_idx_ff;
                  limit_ff <= {1'b0, found_ent_ff.rank};
                  if (req_ff.req_type == lfu_pkg::REQ_GET)
                     rsp_ff.read_value <= found_ent_ff.value;
               end else if (req_ff.req_type == lfu_pkg::REQ_PUT) begin
                  new_ent_ff <= 1'b1;
                  if (occ_ff < eff_cap && free_ff) begin
                     slot_ff <= free_idx_ff;
                     limit_ff <= '1;
                     occ_ff <= occ_ff + CntW'(1);
                     valid_ff[free_idx_ff] <= 1'b1;
                  end else begin
                     slot_ff <= vic_idx_ff;
                     limit_ff <= {1'b0, vic_ent_ff.rank};
                     rsp_ff.evicted <= 1'b1;
                     rsp_ff.evicted_key <= vic_ent_ff.key;
                  end
               end else begin
                  state_ff <= ST_RESP;
               end
            end
            ST_UPDATE: begin
               if (upd_rd) ctr_ff <= ctr_ff + CntW'(1);
               if (!upd_rd && !rd_vld_ff) state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_if.ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== tb/sv/lfu_tb_pkg.sv =====
`timescale 1ns / 100ps
package lfu_tb_pkg;
   localparam int NumSlots = 16;
endpackage

// ===== tb/sv/lfu_cache_checker.sv =====
`timescale 1ns / 100ps
module lfu_cache_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  lfu_pkg::req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  lfu_pkg::rsp_type rsp_payload,
   input  logic csr_wr_en,
   input  logic [lfu_pkg::CfgWidth-1:0] csr_wr_data,
   output int fail_count,
   output int pending_count
);
   localparam int Slots = lfu_tb_pkg::NumSlots;

   logic                           slot_valid [Slots];
   logic [lfu_pkg::KeyWidth-1:0]   slot_key [Slots];
   logic [lfu_pkg::ValueWidth-1:0] slot_value [Slots];
   logic [lfu_pkg::CountWidth-1:0] slot_count [Slots];
   int unsigned                    slot_rank [Slots];
   int unsigned                    fill;
   logic [lfu_pkg::CfgWidth-1:0]   cap_reg;
   lfu_pkg::rsp_type               expected_rsps[$];

   function automatic int unsigned cap_limit();
      int unsigned c;
      c = 32'(cap_reg);
      if (c < 1) c = 1;
      if (c > Slots) c = Slots;
      return c;
   endfunction

   function automatic void make_newest(int s, int unsigned old_rank);
      for (int i = 0; i < Slots; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   function automatic lfu_pkg::rsp_type predict_lookup(lfu_pkg::req_type rq);
      lfu_pkg::rsp_type r;
      int found;
      int slot;
      int unsigned lim;
      found = -1;
      slot = -1;
      r = '{hit: 1'b0, read_value: lfu_pkg::MissValue, evicted: 1'b0, evicted_key: '0};
      for (int i = 0; i < Slots; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == rq.lookup_key) found = i;
      if (found >= 0) begin
         r.hit = 1'b1;
         if (rq.req_type == lfu_pkg::REQ_PUT) slot_value[found] = rq.write_value;
         else r.read_value = slot_value[found];
         if (slot_count[found] != lfu_pkg::CountMax) slot_count[found]++;
         make_newest(found, slot_rank[found]);
      end else if (rq.req_type == lfu_pkg::REQ_PUT) begin
         if (fill < cap_limit())
            for (int i = 0; i < Slots; i++)
               if (slot < 0 && !slot_valid[i]) slot = i;
         if (slot >= 0) begin
            lim = 32'hFFFF_FFFF;
            fill++;
         end else begin
            for (int i = 0; i < Slots; i++) begin
               if (!slot_valid[i]) continue;
               if (slot < 0 || slot_count[i] < slot_count[slot] ||
                   (slot_count[i] == slot_count[slot] && slot_rank[i] > slot_rank[slot]))
                  slot = i;
            end
            r.evicted = 1'b1;
            r.evicted_key = slot_key[slot];
            lim = slot_rank[slot];
         end
         slot_valid[slot] = 1'b1;
         slot_key[slot] = rq.lookup_key;
         slot_value[slot] = rq.write_value;
         slot_count[slot] = 32'd1;
         make_newest(slot, lim);
      end
      return r;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      lfu_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < Slots; i++) slot_valid[i] = 1'b0;
         fill = 0;
         cap_reg = lfu_pkg::CapReset;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) cap_reg = csr_wr_data;
         if (req_valid && req_ready) expected_rsps.push_back(predict_lookup(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item %p", rsp_payload);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
                  fail_count++;
               end
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %0h, got %0h", want.read_value,
                         rsp_payload.read_value);
                  fail_count++;
               end
               if (rsp_payload.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_payload.evicted);
                  fail_count++;
               end
               if (rsp_payload.evicted_key !== want.evicted_key) begin
                  $error("evicted_key: expected %0h, got %0h", want.evicted_key,
                         rsp_payload.evicted_key);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/lfu_cache_replacement_unit_tb.sv =====
`timescale 1ns / 100ps
module lfu_cache_replacement_unit_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [lfu_pkg::CfgWidth-1:0] csr_wr_data = '0;
   logic calm = 1'b0;
   int fail_count;
   int pending_count;
   logic [lfu_pkg::KeyWidth-1:0] key_pool [8];

   lfu_req_if req_if ();
   lfu_rsp_if rsp_if ();

   lfu_cache_replacement_unit #(.CAPACITY(16)) DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   lfu_cache_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   // result side stalls in bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(negedge clock);
      end
   end

   // valid stays high after an accept until the next item or an idle stretch
   task automatic send_item(logic kind, logic [lfu_pkg::KeyWidth-1:0] k,
                            logic [lfu_pkg::ValueWidth-1:0] v);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      req_if.payload <= '{req_type: kind, lookup_key: k, write_value: v};
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle_and_set_capacity(logic [lfu_pkg::CfgWidth-1:0] cap);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (24) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int count, int keys);
      int r;
      logic [lfu_pkg::KeyWidth-1:0] k;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         k = (r == 0) ? $urandom() : key_pool[$urandom_range(0, keys - 1)];
         if (r == 1) k = -k;
         send_item($urandom_range(0, 1) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET, k, $urandom());
      end
   endtask

   initial begin
      logic [lfu_pkg::CfgWidth-1:0] caps [7] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd17, 5'd8};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, hits, misses, evictions, capacity lowered below occupancy
      send_item(lfu_pkg::REQ_GET, 32'h8000_0000, '0);
      send_item(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lfu_pkg::REQ_PUT, 32'h0, 32'h0);
      send_item(lfu_pkg::REQ_GET, 32'h8000_0000, '1);
      send_item(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, '0);
      send_item(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
      send_item(lfu_pkg::REQ_GET, 32'hFFFF_FFFF, '0);
      send_item(lfu_pkg::REQ_GET, 32'h5555_AAAA, '0);
      settle_and_set_capacity(5'd2);
      send_item(lfu_pkg::REQ_PUT, 32'hAAAA_5555, 32'h1);
      send_item(lfu_pkg::REQ_PUT, 32'h1, 32'h2);
      send_item(lfu_pkg::REQ_PUT, 32'h2, 32'h3);
      send_item(lfu_pkg::REQ_GET, 32'h0, '0);

      foreach (caps[c]) begin
         for (int j = 0; j < 8; j++) key_pool[j] = $urandom();
         settle_and_set_capacity(caps[c]);
         random_phase(220, (c % 2) ? 8 : 6);
      end
      calm = 1'b1;
      random_phase(200, 8);
      req_if.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/lfu_pkg.sv
src/lfu_req_if.sv
src/lfu_rsp_if.sv
src/lfu_cache_replacement_unit.sv
tb/sv/lfu_tb_pkg.sv
tb/sv/lfu_cache_checker.sv
tb/sv/lfu_cache_replacement_unit_tb.sv
